### hw/rtl/slfs_pkg.sv
// sleep/listen frame scheduler package
// register indexes, reset values, config and result structures; no dependencies
package slfs_pkg;

  localparam int unsigned SwinW   = 10;
  localparam int unsigned LwinW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLASS_MODE   = 3'd0,
    CFG_INIT_SWIN    = 3'd1,
    CFG_MAX_SWIN     = 3'd2,
    CFG_LISTEN_WIN   = 3'd3,
    CFG_START_OFFSET = 3'd4
  } cfg_idx_e;

  localparam logic             RstClassMode   = 1'b0;
  localparam logic [SwinW-1:0] RstInitSwin    = 10'd1;
  localparam logic [SwinW-1:0] RstMaxSwin     = 10'd64;
  localparam logic [LwinW-1:0] RstListenWin   = 8'd1;
  localparam logic [LwinW-1:0] RstStartOffset = 8'd0;

  typedef struct packed {
    logic             class_mode;
    logic [SwinW-1:0] init_swin;
    logic [SwinW-1:0] max_swin;
    logic [LwinW-1:0] listen_win;
    logic [LwinW-1:0] start_offset;
  } cfg_t;

  typedef struct packed {
    logic             listen;
    logic [SwinW-1:0] swin_now;
  } res_t;

endpackage

### hw/rtl/slfs_cfg_regs.sv
// configuration register file of the sleep/listen frame scheduler
// depends on slfs_pkg
module slfs_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [slfs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [slfs_pkg::CfgDatW-1:0] cfg_data_i,
  output slfs_pkg::cfg_t               cfg_o
);

  slfs_pkg::cfg_t cfg_q, cfg_d;
  logic           wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (slfs_pkg::cfg_idx_e'(cfg_index_i))
        slfs_pkg::CFG_CLASS_MODE:   cfg_d.class_mode   = cfg_data_i[0];
        slfs_pkg::CFG_INIT_SWIN:    cfg_d.init_swin    = cfg_data_i[slfs_pkg::SwinW-1:0];
        slfs_pkg::CFG_MAX_SWIN:     cfg_d.max_swin     = cfg_data_i[slfs_pkg::SwinW-1:0];
        slfs_pkg::CFG_LISTEN_WIN:   cfg_d.listen_win   = cfg_data_i[slfs_pkg::LwinW-1:0];
        slfs_pkg::CFG_START_OFFSET: cfg_d.start_offset = cfg_data_i[slfs_pkg::LwinW-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.class_mode   <= slfs_pkg::RstClassMode;
      cfg_q.init_swin    <= slfs_pkg::RstInitSwin;
      cfg_q.max_swin     <= slfs_pkg::RstMaxSwin;
      cfg_q.listen_win   <= slfs_pkg::RstListenWin;
      cfg_q.start_offset <= slfs_pkg::RstStartOffset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hw/rtl/slfs_sched.sv
// schedule state and per-frame sleep/listen decision
// depends on slfs_pkg
module slfs_sched (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  slfs_pkg::cfg_t cfg_i,
  input  logic           fire_i,
  input  logic           restart_i,
  output slfs_pkg::res_t res_o
);

  logic                       started_q, started_d;
  logic [slfs_pkg::SwinW-1:0] cur_q, cur_d, sl_q, sl_d;
  logic [slfs_pkg::LwinW-1:0] ll_q, ll_d, ol_q, ol_d;

  logic                       reload;
  logic [slfs_pkg::SwinW-1:0] cur_r, sl_r, load_w;
  logic [slfs_pkg::LwinW-1:0] ll_r, ol_r;
  logic [slfs_pkg::SwinW:0]   dbl;
  logic                       lis;

  always_comb begin
    reload = !started_q || restart_i;
    load_w = cfg_i.init_swin;
    if (!cfg_i.class_mode && (cfg_i.init_swin > cfg_i.max_swin)) begin
      load_w = cfg_i.max_swin;
    end
    if (reload) begin
      cur_r = load_w;
      sl_r  = load_w;
      ll_r  = cfg_i.listen_win;
      ol_r  = cfg_i.class_mode ? cfg_i.start_offset : '0;
    end else begin
      cur_r = cur_q;
      sl_r  = sl_q;
      ll_r  = ll_q;
      ol_r  = ol_q;
    end

    dbl  = {cur_r, 1'b0};
    cur_d = cur_r;
    sl_d  = sl_r;
    ll_d  = ll_r;
    ol_d  = ol_r;
    lis   = 1'b1;

    if (ol_r != '0) begin
      ol_d = ol_r - 1'b1;
    end else begin
      // window exhausted: start a new sleep-plus-listen cycle
      if ((sl_r == '0) && (ll_r == '0)) begin
        if (!cfg_i.class_mode) begin
          if ((cur_r < cfg_i.max_swin) && (dbl <= {1'b0, cfg_i.max_swin})) begin
            cur_d = dbl[slfs_pkg::SwinW-1:0];
          end else begin
            cur_d = cfg_i.max_swin;
          end
        end
        sl_d = cur_d;
        ll_d = cfg_i.listen_win;
      end
      if (sl_d != '0) begin
        lis  = 1'b0;
        sl_d = sl_d - 1'b1;
      end else if (ll_d != '0) begin
        ll_d = ll_d - 1'b1;
      end
    end

    started_d = 1'b1;
    res_o.listen   = lis;
    res_o.swin_now = cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      cur_q     <= '0;
      sl_q      <= '0;
      ll_q      <= '0;
      ol_q      <= '0;
    end else if (fire_i) begin
      started_q <= started_d;
      cur_q     <= cur_d;
      sl_q      <= sl_d;
      ll_q      <= ll_d;
      ol_q      <= ol_d;
    end
  end

`ifndef ASSERT_OFF
  a_started_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |=> started_q)
    else $error("schedule not marked started after a request");

  a_sleep_within_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sl_q <= cur_q)
    else $error("sleep count exceeds current window");

  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> ($stable(cur_q) && $stable(sl_q) && $stable(ll_q) && $stable(ol_q)))
    else $error("schedule state moved without a request");
`endif

endmodule

### hw/rtl/slfs_out_buf.sv
// result register with skid stage for the sleep/listen frame scheduler
// depends on slfs_pkg
module slfs_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  slfs_pkg::res_t res_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output slfs_pkg::res_t res_o
);

  logic           out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  slfs_pkg::res_t out_q, out_d, skid_q, skid_d;
  logic           take;

  assign take        = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

`ifndef ASSERT_OFF
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output register is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && take) |=> (out_valid_q && !skid_valid_q))
    else $error("skid result not moved to output register");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !take) |=> skid_valid_q)
    else $error("skid dropped a result while output stalled");
`endif

endmodule

### hw/rtl/sleep_listen_frame_scheduler_unit.sv
// top level of the sleep/listen frame scheduler
// depends on slfs_pkg, slfs_cfg_regs, slfs_sched, slfs_out_buf
//
// channel  direction  handshake                 payload
// cfg      in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
// in       in         in_valid_i / in_stall_o   restart_i
// out      out        out_valid_o / out_stall_i listen_o, sleep_window_now_o
//
// one frame tick a cycle while in_stall_o is low
// the decision is one pass of counter logic into the result or skid register
// reset clears the schedule; the first tick after reset reloads it
// in_stall_o rises only once both the result register and skid stage are full
module sleep_listen_frame_scheduler_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [slfs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [slfs_pkg::CfgDatW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         restart_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         listen_o,
  output logic [slfs_pkg::SwinW-1:0]   sleep_window_now_o
);

  slfs_pkg::cfg_t cfg;
  slfs_pkg::res_t res_new, res_out;
  logic           full, fire;

  assign in_stall_o = full;
  assign fire       = in_valid_i && !full;

  slfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  slfs_sched u_sched (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .fire_i    (fire),
    .restart_i (restart_i),
    .res_o     (res_new)
  );

  slfs_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .res_i       (res_new),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign listen_o           = res_out.listen;
  assign sleep_window_now_o = res_out.swin_now;

endmodule

### verif/slfs_checker.sv
// checker for the sleep/listen frame scheduler: follows the config, request and result channels
// keeps its own schedule model and compares each result against it; depends on slfs_pkg
module slfs_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [slfs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [slfs_pkg::CfgDatW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         restart_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         listen_i,
  input  logic [slfs_pkg::SwinW-1:0]   sleep_window_now_i,
  output int                           errors_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  slfs_pkg::cfg_t             regs_shadow;
  logic                       sched_started;
  logic [slfs_pkg::SwinW-1:0] cur_swin;
  logic [slfs_pkg::SwinW-1:0] sleep_cnt;
  logic [slfs_pkg::LwinW-1:0] listen_cnt;
  logic [slfs_pkg::LwinW-1:0] offset_cnt;
  slfs_pkg::res_t             frame_q[$];

  task automatic predict_frame(input logic rs, output slfs_pkg::res_t r);
    int w;
    if (!sched_started || rs) begin
      w = int'(regs_shadow.init_swin);
      if (!regs_shadow.class_mode && regs_shadow.init_swin > regs_shadow.max_swin) begin
        w = int'(regs_shadow.max_swin);
      end
      cur_swin      = slfs_pkg::SwinW'(w);
      sleep_cnt     = cur_swin;
      listen_cnt    = regs_shadow.listen_win;
      offset_cnt    = regs_shadow.class_mode ? regs_shadow.start_offset : '0;
      sched_started = 1'b1;
    end
    if (offset_cnt != 0) begin
      r.listen   = 1'b1;
      offset_cnt = offset_cnt - 1'b1;
    end else begin
      if (sleep_cnt == 0 && listen_cnt == 0) begin
        if (!regs_shadow.class_mode) begin
          w = int'(cur_swin);
          if (w < regs_shadow.max_swin) begin
            w = w * 2;
            if (w > regs_shadow.max_swin) w = int'(regs_shadow.max_swin);
          end else begin
            w = int'(regs_shadow.max_swin);
          end
          cur_swin = slfs_pkg::SwinW'(w);
        end
        sleep_cnt  = cur_swin;
        listen_cnt = regs_shadow.listen_win;
      end
      if (sleep_cnt != 0) begin
        r.listen  = 1'b0;
        sleep_cnt = sleep_cnt - 1'b1;
      end else if (listen_cnt != 0) begin
        r.listen   = 1'b1;
        listen_cnt = listen_cnt - 1'b1;
      end else begin
        r.listen = 1'b1;
      end
    end
    r.swin_now = cur_swin;
  endtask

  always @(posedge clk_i) begin
    slfs_pkg::res_t exp_r;
    slfs_pkg::res_t new_r;
    if (!rst_ni) begin
      regs_shadow   = '{class_mode:   slfs_pkg::RstClassMode,
                        init_swin:    slfs_pkg::RstInitSwin,
                        max_swin:     slfs_pkg::RstMaxSwin,
                        listen_win:   slfs_pkg::RstListenWin,
                        start_offset: slfs_pkg::RstStartOffset};
      sched_started = 1'b0;
      cur_swin      = '0;
      sleep_cnt     = '0;
      listen_cnt    = '0;
      offset_cnt    = '0;
      frame_q.delete();
      errors_o      = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (frame_q.size() == 0) begin
          $display("%t: unexpected result, expected none, got listen %0d window %0d",
                   $time, listen_i, sleep_window_now_i);
          errors_o++;
        end else begin
          exp_r = frame_q.pop_front();
          if (exp_r.listen !== listen_i) begin
            $display("%t: listen mismatch, expected %0d, got %0d", $time, exp_r.listen,
                     listen_i);
            errors_o++;
          end
          if (exp_r.swin_now !== sleep_window_now_i) begin
            $display("%t: sleep window mismatch, expected %0d, got %0d", $time,
                     exp_r.swin_now, sleep_window_now_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_frame(restart_i, new_r);
        frame_q.push_back(new_r);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (cfg_index_i)
          slfs_pkg::CFG_CLASS_MODE:   regs_shadow.class_mode   = cfg_data_i[0];
          slfs_pkg::CFG_INIT_SWIN:    regs_shadow.init_swin    = cfg_data_i[slfs_pkg::SwinW-1:0];
          slfs_pkg::CFG_MAX_SWIN:     regs_shadow.max_swin     = cfg_data_i[slfs_pkg::SwinW-1:0];
          slfs_pkg::CFG_LISTEN_WIN:   regs_shadow.listen_win   = cfg_data_i[slfs_pkg::LwinW-1:0];
          slfs_pkg::CFG_START_OFFSET: regs_shadow.start_offset = cfg_data_i[slfs_pkg::LwinW-1:0];
          default: ;
        endcase
      end
    end
    pending_o = frame_q.size();
  end

endmodule

### verif/tb_top.sv
// testbench top for sleep_listen_frame_scheduler_unit: clock, reset, config and frame requests
// depends on slfs_pkg, the scheduler rtl and slfs_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [slfs_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [slfs_pkg::CfgDatW-1:0] cfg_data_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         restart_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic                         listen_o;
  logic [slfs_pkg::SwinW-1:0]   sleep_window_now_o;
  int                           errors;
  int                           pending;
  int                           idle_odds;
  int                           stall_odds;

  sleep_listen_frame_scheduler_unit u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .restart_i,
    .out_valid_o, .out_stall_i, .listen_o, .sleep_window_now_o
  );

  slfs_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i (cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i (in_stall_o), .restart_i,
    .out_valid_i (out_valid_o), .out_stall_i, .listen_i (listen_o),
    .sleep_window_now_i (sleep_window_now_o),
    .errors_o (errors), .pending_o (pending)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // result side back-pressure in bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  function automatic int pick_win(input int hi);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return hi;
      2: return $urandom_range(0, hi);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  task automatic send_frame(input logic rs);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid_i = 1'b0;
      restart_i  = 1'($urandom);
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    restart_i  = rs;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic run_frames(input int n, input logic first_rs, input int restart_one_in);
    for (int k = 0; k < n; k++) begin
      if (k == 0) send_frame(first_rs);
      else send_frame(restart_one_in != 0 && $urandom_range(1, restart_one_in) == 1);
    end
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input slfs_pkg::cfg_idx_e idx,
                           input logic [slfs_pkg::CfgDatW-1:0] d);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic program_regs(input slfs_pkg::cfg_t c);
    in_valid_i = 1'b0;
    wait_idle();
    write_reg(slfs_pkg::CFG_CLASS_MODE, slfs_pkg::CfgDatW'(c.class_mode));
    write_reg(slfs_pkg::CFG_INIT_SWIN, c.init_swin);
    write_reg(slfs_pkg::CFG_MAX_SWIN, c.max_swin);
    write_reg(slfs_pkg::CFG_LISTEN_WIN, slfs_pkg::CfgDatW'(c.listen_win));
    write_reg(slfs_pkg::CFG_START_OFFSET, slfs_pkg::CfgDatW'(c.start_offset));
    // unused indexes must be ignored
    if ($urandom_range(0, 5) == 0) begin
      write_reg(slfs_pkg::cfg_idx_e'(slfs_pkg::CFG_START_OFFSET + $urandom_range(1, 3)),
                slfs_pkg::CfgDatW'($urandom_range(0, 1023)));
    end
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    slfs_pkg::cfg_t c;
    int             left;
    int             n;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = slfs_pkg::CFG_CLASS_MODE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    restart_i   = 1'b0;
    idle_odds   = 4;
    stall_odds  = 4;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings, first request reloads without restart
    send_frame(1'b0);
    send_frame(1'b0);
    send_frame(1'b0);
    send_frame(1'b1);
    send_frame(1'b0);
    // initial above maximum in class i
    c = '{class_mode: 1'b0, init_swin: 10'd1023, max_swin: 10'd3, listen_win: 8'd2,
          start_offset: 8'd255};
    program_regs(c);
    run_frames(5, 1'b1, 0);
    // maximum lowered mid-schedule
    c.max_swin = 10'd1;
    program_regs(c);
    run_frames(3, 1'b0, 0);
    // class ii with offset and zero sleep window
    c = '{class_mode: 1'b1, init_swin: 10'd0, max_swin: 10'd1023, listen_win: 8'd2,
          start_offset: 8'd2};
    program_regs(c);
    run_frames(5, 1'b1, 0);
    // zero listen window
    c = '{class_mode: 1'b1, init_swin: 10'd2, max_swin: 10'd0, listen_win: 8'd0,
          start_offset: 8'd0};
    program_regs(c);
    run_frames(3, 1'b1, 0);
    // both windows zero
    c = '{class_mode: 1'b0, init_swin: 10'd0, max_swin: 10'd0, listen_win: 8'd0,
          start_offset: 8'd0};
    program_regs(c);
    run_frames(3, 1'b1, 0);

    left = 950;
    while (left > 0) begin
      n = $urandom_range(10, 80);
      if (n > left) n = left;
      if (left <= 150) begin
        idle_odds  = 0;
        stall_odds = 0;
      end else begin
        idle_odds  = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 12);
        stall_odds = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 12);
      end
      c.class_mode   = 1'($urandom);
      c.init_swin    = slfs_pkg::SwinW'(pick_win(1023));
      c.max_swin     = slfs_pkg::SwinW'(pick_win(1023));
      c.listen_win   = slfs_pkg::LwinW'(pick_win(255));
      c.start_offset = slfs_pkg::LwinW'(pick_win(255));
      program_regs(c);
      run_frames(n, $urandom_range(0, 3) != 0, $urandom_range(0, 1) == 0 ? 0 : 40);
      left -= n;
    end

    in_valid_i = 1'b0;
    wait_idle();
    repeat (8) @(negedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
